[rtl/core/periodic_timer_with_overruns_assert.svh]
// Assertion macros for the periodic timer checker
`ifndef PERIODIC_TIMER_WITH_OVERRUNS_ASSERT_SVH
`define PERIODIC_TIMER_WITH_OVERRUNS_ASSERT_SVH

// Clocked on clock, masked while reset is high
`define PTWO_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked on clock, also checked across reset
`define PTWO_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/core/ptwo_pkg.sv]
// Package: shared codes and types of the periodic timer
`timescale 1ns / 1ps
`default_nettype none
package ptwo_pkg;

   localparam int MODE_BITS = 2;

   localparam logic [MODE_BITS-1:0] MODE_OBSERVE    = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_SCHEDULE   = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_READ_CLEAR = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_ADVANCE,
      ST_REPORT
   } state_type;

endpackage
`default_nettype wire

[rtl/core/ptwo_ifs.sv]
// Request and response channel interfaces of the periodic timer
`timescale 1ns / 1ps
`default_nettype none
interface ptwo_req_if import ptwo_pkg::*; #(
   parameter int TIME_BITS = 48
);
   logic                 valid;
   logic                 ready;
   logic [MODE_BITS-1:0] mode;
   logic [TIME_BITS-1:0] now_time;
   logic                 is_absolute;
   logic [TIME_BITS-1:0] start_time;
   logic [TIME_BITS-1:0] period_ticks;

   modport source (output valid, mode, now_time, is_absolute, start_time, period_ticks,
                   input ready);
   modport sink   (input valid, mode, now_time, is_absolute, start_time, period_ticks,
                   output ready);
endinterface

interface ptwo_rsp_if #(
   parameter int OVERRUN_BITS = 32
);
   logic                    valid;
   logic                    ready;
   logic                    fired;
   logic [OVERRUN_BITS-1:0] overrun_count;
   logic                    armed;

   modport source (output valid, fired, overrun_count, armed, input ready);
   modport sink   (input valid, fired, overrun_count, armed, output ready);
endinterface
`default_nettype wire

[rtl/core/ptwo_divider.sv]
// Bit-serial restoring divider: one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module ptwo_divider #(
   parameter int WIDTH = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int CNT_BITS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0]    quo_ff, quo_in;   // dividend shifts out, quotient shifts in
   logic [WIDTH-1:0]    rem_ff, rem_in;
   logic [WIDTH-1:0]    dvs_ff, dvs_in;
   logic [WIDTH:0]      shifted;
   logic [WIDTH+1:0]    trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[WIDTH-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(WIDTH - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!trial[WIDTH+1]) begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

[rtl/core/periodic_timer_with_overruns.sv]
// Top level: periodic deadline timer with a saturating overrun counter
//
// One request transaction in, one response transaction out. A request carries
// the current time and a mode: observe (check the deadline, fire, skip missed
// periods), schedule (set deadline and period; a start of zero disarms) or
// read-clear (report the overrun count, then zero it). The block handles one
// request at a time; the next request is taken as soon as the previous
// result sits in the response register, even if the sink has not taken it.
// Steps per request: the request is latched and then worked in EXEC. An
// observe past the deadline of a periodic timer passes through DIV and then
// ADVANCE, and any other observe that fires through ADVANCE alone, before
// REPORT loads the response register. The DIV step waits on the bit-serial
// divider, which works out the number of missed periods one quotient bit per
// cycle. A stalled response sink holds the block in its report step.
`timescale 1ns / 1ps
`default_nettype none
module periodic_timer_with_overruns import ptwo_pkg::*; #(
   parameter int TIME_BITS    = 48,
   parameter int OVERRUN_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   ptwo_req_if.sink   req_chan,
   ptwo_rsp_if.source rsp_chan
);

   // Width used to add the quotient into the overrun counter without loss
   localparam int SUM_BITS =
      ((TIME_BITS > OVERRUN_BITS) ? TIME_BITS : OVERRUN_BITS) + 1;
   localparam logic [SUM_BITS-1:0] OVR_LIMIT = SUM_BITS'({OVERRUN_BITS{1'b1}});

   state_type state_ff, state_in;

   // Latched request
   logic [MODE_BITS-1:0] mode_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic                 abs_ff;
   logic [TIME_BITS-1:0] start_ff;
   logic [TIME_BITS-1:0] per_ff;

   // Timer state
   logic [TIME_BITS-1:0]    deadline_ff, deadline_in;
   logic [TIME_BITS-1:0]    period_ff, period_in;
   logic [OVERRUN_BITS-1:0] missed_ff, missed_in;
   logic                    fired_ff, fired_in;

   // Response register
   logic                    rsp_valid_ff;
   logic                    rsp_fired_ff;
   logic [OVERRUN_BITS-1:0] rsp_count_ff;
   logic                    rsp_armed_ff;

   logic                 req_take;
   logic                 rsp_free;
   logic                 rsp_load;
   logic [TIME_BITS:0]   gap;        // now - deadline, top bit is the borrow
   logic                 now_ge;
   logic                 now_gt;
   logic [TIME_BITS-1:0] add_a, add_b;
   logic [TIME_BITS:0]   add_sum;
   logic [TIME_BITS-1:0] add_sat;    // saturating sum
   logic [SUM_BITS-1:0]  miss_sum;

   logic                 div_start;
   logic                 div_done;
   logic [TIME_BITS-1:0] div_quo;
   logic [TIME_BITS-1:0] div_rem;

   assign req_take = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_load = (state_ff == ST_REPORT) && rsp_free;

   assign req_chan.ready = (state_ff == ST_IDLE);

   assign gap    = {1'b0, now_ff} - {1'b0, deadline_ff};
   assign now_ge = !gap[TIME_BITS];
   assign now_gt = now_ge && (gap[TIME_BITS-1:0] != '0);

   // One adder: relative start on schedule, deadline advance on fire
   assign add_a   = (state_ff == ST_ADVANCE) ? deadline_ff : now_ff;
   assign add_b   = (state_ff == ST_ADVANCE) ? period_ff : start_ff;
   assign add_sum = {1'b0, add_a} + {1'b0, add_b};
   assign add_sat = add_sum[TIME_BITS] ? '1 : add_sum[TIME_BITS-1:0];

   assign miss_sum = SUM_BITS'(missed_ff) + SUM_BITS'(div_quo);

   ptwo_divider #(
      .WIDTH (TIME_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (gap[TIME_BITS-1:0]),
      .divisor   (period_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      state_in    = state_ff;
      deadline_in = deadline_ff;
      period_in   = period_ff;
      missed_in   = missed_ff;
      fired_in    = fired_ff;
      div_start   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               fired_in = 1'b0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_REPORT;
            case (mode_ff)
               MODE_SCHEDULE: begin
                  if (start_ff == '0) begin
                     deadline_in = '0;
                     period_in   = '0;
                  end else begin
                     deadline_in = abs_ff ? start_ff : add_sat;
                     period_in   = per_ff;
                  end
               end
               MODE_OBSERVE: begin
                  if (deadline_ff != '0) begin
                     if ((period_ff != '0) && now_gt) begin
                        // past the deadline: count whole missed periods
                        div_start = 1'b1;
                        state_in  = ST_DIV;
                     end else if (now_ge) begin
                        state_in = ST_ADVANCE;
                     end
                  end
               end
               default: ;
            endcase
         end
         ST_DIV: begin
            if (div_done) begin
               // deadline + misses * period == now - remainder
               deadline_in = now_ff - div_rem;
               missed_in   = (miss_sum > OVR_LIMIT) ? '1 : miss_sum[OVERRUN_BITS-1:0];
               state_in    = ST_ADVANCE;
            end
         end
         ST_ADVANCE: begin
            fired_in    = 1'b1;
            deadline_in = (period_ff == '0) ? '0 : add_sat;
            state_in    = ST_REPORT;
         end
         ST_REPORT: begin
            if (rsp_free) begin
               if (mode_ff == MODE_READ_CLEAR) begin
                  missed_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         deadline_ff <= '0;
         period_ff   <= '0;
         missed_ff   <= '0;
         fired_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         deadline_ff <= deadline_in;
         period_ff   <= period_in;
         missed_ff   <= missed_in;
         fired_ff    <= fired_in;
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff  <= req_chan.mode;
         now_ff   <= req_chan.now_time;
         abs_ff   <= req_chan.is_absolute;
         start_ff <= req_chan.start_time;
         per_ff   <= req_chan.period_ticks;
      end
   end

   // Response register: report reads the counter before any clear
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_fired_ff <= fired_ff;
         rsp_count_ff <= missed_ff;
         rsp_armed_ff <= (deadline_ff != '0);
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.fired         = rsp_fired_ff;
   assign rsp_chan.overrun_count = rsp_count_ff;
   assign rsp_chan.armed         = rsp_armed_ff;

endmodule
`default_nettype wire

[rtl/core/ptwo_checker.sv]
// Port-level checker for the periodic timer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_timer_with_overruns_assert.svh"
module ptwo_checker #(
   parameter int OVERRUN_BITS = 32
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic                    rsp_fired,
   input logic [OVERRUN_BITS-1:0] rsp_overrun_count,
   input logic                    rsp_armed
);

   // no response right after reset
   `PTWO_ASSERT_RST(a_rsp_idle_after_reset, reset |=> !rsp_valid, "response valid after reset")

   // one transaction in flight: ready drops after an accept
   `PTWO_ASSERT(a_busy_after_accept, req_valid && req_ready |=> !req_ready, "ready held after accept")

   // a response does not appear straight after the accept of its request
   `PTWO_ASSERT(a_no_instant_rsp, req_valid && req_ready && !rsp_valid |=> !rsp_valid, "response too early")

   // stalled response holds
   `PTWO_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fired) && $stable(rsp_overrun_count) && $stable(rsp_armed), "stalled response changed")

endmodule

bind periodic_timer_with_overruns ptwo_checker #(
   .OVERRUN_BITS (OVERRUN_BITS)
) u_ptwo_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_fired         (rsp_chan.fired),
   .rsp_overrun_count (rsp_chan.overrun_count),
   .rsp_armed         (rsp_chan.armed)
);
`default_nettype wire

[tb/sv/tb_periodic_timer_with_overruns.sv]
// Testbench: periodic deadline timer checked transaction by transaction against a predictor
`timescale 1ns / 1ps
module tb_periodic_timer_with_overruns;
   import ptwo_pkg::*;

   localparam int TIME_BITS    = 48;
   localparam int OVERRUN_BITS = 32;

   // Largest time value and largest overrun count; both are saturation points.
   localparam longint unsigned TIME_MAX = (64'd1 << TIME_BITS) - 1;
   localparam logic [OVERRUN_BITS-1:0] OVERRUN_MAX = '1;

   // Mode 3 is not decoded by the block: it must leave the state alone.
   localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

   localparam int DIRECTED_ITEMS = 25;
   localparam int RANDOM_ITEMS   = 1100;

   // One request transaction. hold makes the driver wait for every pending
   // response before it presents this one.
   typedef struct {
      logic [MODE_BITS-1:0] mode;
      logic [TIME_BITS-1:0] now_time;
      logic                 is_absolute;
      logic [TIME_BITS-1:0] start_time;
      logic [TIME_BITS-1:0] period_ticks;
      bit                   hold;
   } timer_cmd_type;

   // One response transaction.
   typedef struct {
      logic                    fired;
      logic [OVERRUN_BITS-1:0] overrun_count;
      logic                    armed;
   } timer_status_type;

   logic clock;
   logic reset;

   ptwo_req_if #(.TIME_BITS(TIME_BITS))       req_chan ();
   ptwo_rsp_if #(.OVERRUN_BITS(OVERRUN_BITS)) rsp_chan ();

   periodic_timer_with_overruns #(
      .TIME_BITS   (TIME_BITS),
      .OVERRUN_BITS(OVERRUN_BITS)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   timer_cmd_type    cmd_q[$];      // requests not yet accepted by the block
   timer_status_type status_q[$];   // predicted responses, oldest first
   timer_status_type got_status;

   // Predictor state, updated when a request is accepted.
   logic [TIME_BITS-1:0]    tmr_deadline;
   logic [TIME_BITS-1:0]    tmr_period;
   logic [OVERRUN_BITS-1:0] tmr_overruns;

   longint unsigned stim_now;    // running time base of the stimulus
   int  n_accepted;
   int  n_checked;
   int  n_errors;
   bit  drv_busy;
   int  drv_wait;
   int  mon_wait;

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic longint unsigned clip_time(longint unsigned t);
      return (t > TIME_MAX) ? TIME_MAX : t;
   endfunction

   function automatic logic [TIME_BITS-1:0] time_add_sat(logic [TIME_BITS-1:0] a,
                                                         logic [TIME_BITS-1:0] b);
      logic [TIME_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_BITS] ? TIME_MAX[TIME_BITS-1:0] : sum[TIME_BITS-1:0];
   endfunction

   // Applies one accepted request to the predictor state and returns the
   // response the block must produce for it.
   function automatic timer_status_type timer_update(timer_cmd_type c);
      timer_status_type     s;
      logic [TIME_BITS-1:0] skipped;
      s.fired = 1'b0;
      if (c.mode == MODE_SCHEDULE) begin
         if (c.start_time == '0) begin
            // zero start disarms, absolute or relative alike
            tmr_deadline = '0;
            tmr_period   = '0;
         end else begin
            tmr_deadline = c.is_absolute ? c.start_time
                                         : time_add_sat(c.now_time, c.start_time);
            tmr_period   = c.period_ticks;
         end
      end else if (c.mode == MODE_OBSERVE && tmr_deadline != '0) begin
         // periodic and late: jump over whole missed periods, count them
         if (tmr_period != '0 && c.now_time > tmr_deadline) begin
            skipped      = (c.now_time - tmr_deadline) / tmr_period;
            tmr_deadline = tmr_deadline + skipped * tmr_period;
            if (skipped > {{(TIME_BITS-OVERRUN_BITS){1'b0}}, OVERRUN_MAX - tmr_overruns})
               tmr_overruns = OVERRUN_MAX;
            else
               tmr_overruns = tmr_overruns + skipped[OVERRUN_BITS-1:0];
         end
         if (c.now_time >= tmr_deadline) begin
            s.fired      = 1'b1;
            tmr_deadline = (tmr_period == '0) ? '0 : time_add_sat(tmr_deadline, tmr_period);
         end
      end
      s.overrun_count = tmr_overruns;
      if (c.mode == MODE_READ_CLEAR)
         tmr_overruns = '0;
      s.armed = (tmr_deadline != '0);
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   function automatic longint unsigned rand_time();
      return {$urandom(), $urandom()} & TIME_MAX;
   endfunction

   task automatic push_cmd(input logic [MODE_BITS-1:0] md, input longint unsigned t,
                           input logic ab, input longint unsigned st,
                           input longint unsigned pr, input bit hold);
      timer_cmd_type c;
      c.mode         = md;
      c.now_time     = t[TIME_BITS-1:0];
      c.is_absolute  = ab;
      c.start_time   = st[TIME_BITS-1:0];
      c.period_ticks = pr[TIME_BITS-1:0];
      c.hold         = hold;
      cmd_q.push_back(c);
   endtask

   // A schedule followed by observes placed around the deadlines it implies:
   // exactly on a deadline, one tick short, a few periods late, far late,
   // repeated time and time stepping back. Read-clears are mixed in.
   task automatic add_episode();
      longint unsigned per, st, dl, t;
      bit ab;
      int k, n, pick;
      case ($urandom_range(0, 19))
         0: stim_now = rand_time();
         1: stim_now = TIME_MAX - $urandom_range(0, 2000);
         2: stim_now = $urandom_range(0, 1000);
         default: ;
      endcase
      case ($urandom_range(0, 9))
         0, 1:       per = 0;
         2, 3, 4, 5: per = $urandom_range(1, 40);
         6, 7:       per = $urandom_range(41, 100000);
         8:          per = rand_time();
         default:    per = $urandom_range(1, 3);
      endcase
      ab   = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 19);
      if (pick == 0)
         st = 0;
      else if (pick < 3)
         st = rand_time();
      else if (ab)
         st = clip_time(stim_now + $urandom_range(0, 200));
      else
         st = $urandom_range(1, 200);
      dl = (st == 0) ? 0 : (ab ? st : clip_time(stim_now + st));
      push_cmd(MODE_SCHEDULE, stim_now, ab, st, per, $urandom_range(0, 40) == 0);

      k = 0;
      n = $urandom_range(2, 10);
      repeat (n) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2: begin
               k += $urandom_range(0, 2);
               t = dl + k * per;
            end
            3, 4: begin
               k += 1;
               t = (dl + k * per > 0) ? dl + k * per - 1 : 0;
            end
            5: begin
               k += $urandom_range(1, 4);
               t = dl + k * per + ((per != 0) ? rand_time() % per : $urandom_range(0, 3));
            end
            6:       t = dl + rand_time();
            8:       t = (stim_now > 50) ? stim_now - $urandom_range(1, 50) : stim_now;
            default: t = stim_now;
         endcase
         t = clip_time(t);
         // only the step-back pick may move time backwards
         if (t < stim_now && pick != 8)
            t = stim_now;
         stim_now = t;
         push_cmd((pick == 9) ? MODE_READ_CLEAR : MODE_OBSERVE, t, 1'($urandom_range(0, 1)),
                  rand_time(), rand_time(), 0);
      end
   endtask

   // A lone request with random mode (unused code included) and random fields.
   task automatic add_noise();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5)
         stim_now = clip_time(stim_now + $urandom_range(0, 500));
      else if (pick < 7)
         stim_now = rand_time();
      push_cmd(MODE_BITS'($urandom_range(0, 3)), stim_now, 1'($urandom_range(0, 1)),
               ($urandom_range(0, 7) == 0) ? 0 : rand_time(),
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 50) : rand_time(),
               $urandom_range(0, 49) == 0);
   endtask

   // Per-transaction wait; every fourth stretch of 48 runs without idling.
   function automatic int pick_wait(int count);
      if ((count / 48) % 4 == 1)
         return 0;
      return $urandom_range(0, 15);
   endfunction

   // ---------------------------------------------------------------------
   // Driver: presents queued requests, predicts each one on acceptance
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid        <= 1'b0;
         req_chan.mode         <= MODE_OBSERVE;
         req_chan.now_time     <= '0;
         req_chan.is_absolute  <= 1'b0;
         req_chan.start_time   <= '0;
         req_chan.period_ticks <= '0;
         drv_busy = 1'b0;
         drv_wait = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            status_q.push_back(timer_update(cmd_q.pop_front()));
            n_accepted++;
            drv_busy = 1'b0;
            drv_wait = pick_wait(n_accepted);
         end
         if (!drv_busy) begin
            if (drv_wait > 0)
               drv_wait--;
            else if (cmd_q.size() != 0 && !(cmd_q[0].hold && status_q.size() != 0)) begin
               req_chan.mode         <= cmd_q[0].mode;
               req_chan.now_time     <= cmd_q[0].now_time;
               req_chan.is_absolute  <= cmd_q[0].is_absolute;
               req_chan.start_time   <= cmd_q[0].start_time;
               req_chan.period_ticks <= cmd_q[0].period_ticks;
               drv_busy = 1'b1;
            end
         end
         // single assignment per edge: back-to-back transactions keep valid high
         req_chan.valid <= drv_busy;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: takes responses with random stalls, compares field by field
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         mon_wait = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            n_checked++;
            if (status_q.size() == 0) begin
               $display("%0t: response with none expected: fired %0d overruns %0d armed %0d",
                        $time, rsp_chan.fired, rsp_chan.overrun_count, rsp_chan.armed);
               n_errors++;
            end else begin
               got_status = status_q.pop_front();
               if (rsp_chan.fired !== got_status.fired) begin
                  $display("%0t: fired expected %0d actual %0d",
                           $time, got_status.fired, rsp_chan.fired);
                  n_errors++;
               end
               if (rsp_chan.overrun_count !== got_status.overrun_count) begin
                  $display("%0t: overrun_count expected %0d actual %0d",
                           $time, got_status.overrun_count, rsp_chan.overrun_count);
                  n_errors++;
               end
               if (rsp_chan.armed !== got_status.armed) begin
                  $display("%0t: armed expected %0d actual %0d",
                           $time, got_status.armed, rsp_chan.armed);
                  n_errors++;
               end
            end
            mon_wait = pick_wait(n_checked + 100);
         end else if (mon_wait > 0) begin
            mon_wait--;
         end
         rsp_chan.ready <= (mon_wait == 0);
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset        = 1'b1;
      tmr_deadline = '0;
      tmr_period   = '0;
      tmr_overruns = '0;
      n_accepted   = 0;
      n_checked    = 0;
      n_errors     = 0;

      // Directed part.
      push_cmd(MODE_OBSERVE, 0, 0, 0, 0, 0);                    // observe while disarmed
      push_cmd(MODE_UNUSED, 10, 1, TIME_MAX, TIME_MAX, 0);      // unused mode
      push_cmd(MODE_READ_CLEAR, 20, 0, 0, 0, 0);
      push_cmd(MODE_SCHEDULE, 50, 1, 100, 10, 0);               // absolute, period 10
      push_cmd(MODE_OBSERVE, 99, 0, 0, 0, 0);                   // one tick short
      push_cmd(MODE_OBSERVE, 100, 0, 0, 0, 0);                  // exactly on the deadline
      push_cmd(MODE_OBSERVE, 145, 0, 0, 0, 0);                  // three periods missed
      push_cmd(MODE_UNUSED, 145, 0, 0, 0, 0);
      push_cmd(MODE_READ_CLEAR, 145, 0, 0, 0, 0);
      push_cmd(MODE_READ_CLEAR, 146, 0, 0, 0, 0);
      push_cmd(MODE_SCHEDULE, 150, 0, 0, 25, 0);                // relative zero disarms
      push_cmd(MODE_OBSERVE, 200, 0, 0, 0, 0);
      push_cmd(MODE_SCHEDULE, 200, 0, 5, 0, 0);                 // relative one-shot
      push_cmd(MODE_OBSERVE, 204, 0, 0, 0, 0);
      push_cmd(MODE_OBSERVE, 300, 0, 0, 0, 0);                  // fires and disarms
      push_cmd(MODE_OBSERVE, 400, 0, 0, 0, 0);
      push_cmd(MODE_SCHEDULE, 400, 1, 1, 1, 0);                 // period 1, deadline 1
      push_cmd(MODE_OBSERVE, 64'd1 << 40, 0, 0, 0, 0);          // overrun count saturates
      push_cmd(MODE_READ_CLEAR, 64'd1 << 40, 0, 0, 0, 0);
      push_cmd(MODE_SCHEDULE, TIME_MAX - 10, 0, 100, TIME_MAX, 0); // relative saturates
      push_cmd(MODE_OBSERVE, TIME_MAX, 0, 0, 0, 0);             // deadline advance saturates
      push_cmd(MODE_OBSERVE, 5, 0, 0, 0, 0);                    // time stepping back
      push_cmd(MODE_SCHEDULE, 5, 1, 0, 7, 0);                   // absolute zero disarms
      push_cmd(MODE_SCHEDULE, 6, 1, TIME_MAX, 0, 0);
      push_cmd(MODE_OBSERVE, TIME_MAX, 0, 0, 0, 1);             // sender drains first

      // Random part: mostly schedule-then-observe episodes, some lone noise.
      stim_now = 0;
      while (cmd_q.size() < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 7)
            add_episode();
         else
            add_noise();
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request to go in and every response to come back,
      // then leave room for a late or extra response.
      while (cmd_q.size() != 0 || status_q.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);

      if (n_errors == 0)
         $display("** periodic_timer_with_overruns: PASSED **");
      else
         $display("** periodic_timer_with_overruns: FAILED **");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("** periodic_timer_with_overruns: FAILED **");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/ptwo_pkg.sv
rtl/core/ptwo_ifs.sv
rtl/core/ptwo_divider.sv
rtl/core/periodic_timer_with_overruns.sv
rtl/core/ptwo_checker.sv
tb/sv/tb_periodic_timer_with_overruns.sv
